### hw/rtl/m3i_pkg.sv
// shared widths, types and sideband struct for the 3x3 matrix inverse
package m3i_pkg;

    localparam int ELEM_WIDTH   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int N_ELEM       = 9;
    localparam int PROD_W       = 2 * ELEM_WIDTH;
    localparam int COF_W        = PROD_W + 1;
    localparam int DPROD_W      = ELEM_WIDTH + COF_W;
    localparam int DET_W        = DPROD_W + 2;
    localparam int NUM_W        = COF_W + 2 * FRAC_BITS;
    localparam int REM_W        = DET_W + ELEM_WIDTH;
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STAGES   = ELEM_WIDTH + 2;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [COF_W-1:0]      t_cof;
    typedef logic signed [DPROD_W-1:0]    t_dprod;
    typedef logic signed [DET_W-1:0]      t_det;
    typedef logic signed [NUM_W-1:0]      t_num;
    typedef logic [NUM_W-1:0]             t_nmag;
    typedef logic [DET_W-1:0]             t_dmag;
    typedef logic [REM_W-1:0]             t_rem;
    typedef logic [ELEM_WIDTH-1:0]        t_quo;

    // front end to divider lanes: shared divisor, per-lane sign and singular flag
    typedef struct packed {
        logic [N_ELEM-1:0] neg;
        t_dmag             dmag;
        logic              singular;
    } t_front_side;

endpackage

### hw/rtl/matrix3x3_inverse.sv
// top level of the pipelined 3x3 fixed-point matrix inverse
//
// Input word: nine signed Q8.8 elements i_m00..i_m22 with i_valid; the
// block drives o_stall. A word is taken at a clock edge with i_valid high
// and o_stall low. Output word: o_r00..o_r22 (inverse, Q8.8, truncated
// toward zero and saturated) and o_singular, with o_valid; the receiver
// drives i_stall and the word is taken when o_valid is high and i_stall low.
// A singular matrix gives o_singular = 1 and all-zero elements.
// Pipeline stages, in order: minor products, cofactors, first-row products,
// determinant and magnitudes in the front end, an overflow check, a stage
// per quotient bit in nine parallel divider lanes, and the output register.
// Throughput is one matrix per cycle unless the pipeline holds; the nine
// divider lanes and the multipliers in the front end are fully pipelined.
// The whole pipeline advances together: it holds only while a result sits
// in the output register and i_stall is high, and o_stall is high exactly
// then. Bubbles move forward freely otherwise.
// Synchronous active-low reset clears all valid bits; no word is in flight
// afterwards. Data registers are not reset.
module matrix3x3_inverse import m3i_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_elem i_m00,
    input  t_elem i_m01,
    input  t_elem i_m02,
    input  t_elem i_m10,
    input  t_elem i_m11,
    input  t_elem i_m12,
    input  t_elem i_m20,
    input  t_elem i_m21,
    input  t_elem i_m22,
    output logic  o_valid,
    input  logic  i_stall,
    output t_elem o_r00,
    output t_elem o_r01,
    output t_elem o_r02,
    output t_elem o_r10,
    output t_elem o_r11,
    output t_elem o_r12,
    output t_elem o_r20,
    output t_elem o_r21,
    output t_elem o_r22,
    output logic  o_singular
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] r_v;
    logic                  r_sing [ELEM_WIDTH+1];
    logic                  r_sing_out;
    t_elem                 m   [N_ELEM];
    t_nmag                 nmag [N_ELEM];
    t_elem                 res [N_ELEM];
    t_front_side           side;

    assign m[0] = i_m00;
    assign m[1] = i_m01;
    assign m[2] = i_m02;
    assign m[3] = i_m10;
    assign m[4] = i_m11;
    assign m[5] = i_m12;
    assign m[6] = i_m20;
    assign m[7] = i_m21;
    assign m[8] = i_m22;

    // pipeline moves unless a finished word is held by the receiver
    assign en      = !r_v[PIPE_DEPTH-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_v[PIPE_DEPTH-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // singular flag follows the divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing[0] <= side.singular;
            for (int k = 1; k <= ELEM_WIDTH; k++) begin
                r_sing[k] <= r_sing[k-1];
            end
            r_sing_out <= r_sing[ELEM_WIDTH];
        end
    end

    m3i_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_m    (m),
        .o_nmag (nmag),
        .o_side (side)
    );

    for (genvar j = 0; j < N_ELEM; j++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_nmag     (nmag[j]),
            .i_dmag     (side.dmag),
            .i_neg      (side.neg[j]),
            .i_singular (r_sing[ELEM_WIDTH]),
            .o_res      (res[j])
        );
    end

    assign o_r00      = res[0];
    assign o_r01      = res[1];
    assign o_r02      = res[2];
    assign o_r10      = res[3];
    assign o_r11      = res[4];
    assign o_r12      = res[5];
    assign o_r20      = res[6];
    assign o_r21      = res[7];
    assign o_r22      = res[8];
    assign o_singular = r_sing_out;

    // input stall comes only from a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output word");

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted word lost at pipeline entry");

    // a held output word does not leave
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_r00) && $stable(o_singular)))
        else $error("held output word changed");

    // singular results carry all-zero elements
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_r00 == '0 && o_r01 == '0 && o_r02 == '0 &&
            o_r10 == '0 && o_r11 == '0 && o_r12 == '0 &&
            o_r20 == '0 && o_r21 == '0 && o_r22 == '0))
        else $error("singular result with nonzero elements");

endmodule

### hw/rtl/m3i_front.sv
// cofactor, determinant and magnitude stages of the 3x3 matrix inverse
module m3i_front import m3i_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_elem       i_m [N_ELEM],
    output t_nmag       o_nmag [N_ELEM],
    output t_front_side o_side
);

    function automatic t_prod mul_elem(input t_elem x, input t_elem y);
        return t_prod'(x) * t_prod'(y);
    endfunction

    t_prod  r_pp [N_ELEM];
    t_prod  r_pq [N_ELEM];
    t_elem  r_a0, r_b0, r_c0, r_a1, r_b1, r_c1;
    t_cof   r_adj1 [N_ELEM];
    t_cof   r_adj2 [N_ELEM];
    t_cof   r_adj3 [N_ELEM];
    t_dprod r_dp [3];
    t_det   r_det;
    t_nmag  r_nmag [N_ELEM];
    t_front_side r_side;

    // stage 0: the eighteen 2x2 minor products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp[0] <= mul_elem(i_m[4], i_m[8]);  r_pq[0] <= mul_elem(i_m[5], i_m[7]);
            r_pp[1] <= mul_elem(i_m[2], i_m[7]);  r_pq[1] <= mul_elem(i_m[1], i_m[8]);
            r_pp[2] <= mul_elem(i_m[1], i_m[5]);  r_pq[2] <= mul_elem(i_m[2], i_m[4]);
            r_pp[3] <= mul_elem(i_m[5], i_m[6]);  r_pq[3] <= mul_elem(i_m[3], i_m[8]);
            r_pp[4] <= mul_elem(i_m[0], i_m[8]);  r_pq[4] <= mul_elem(i_m[2], i_m[6]);
            r_pp[5] <= mul_elem(i_m[2], i_m[3]);  r_pq[5] <= mul_elem(i_m[0], i_m[5]);
            r_pp[6] <= mul_elem(i_m[3], i_m[7]);  r_pq[6] <= mul_elem(i_m[4], i_m[6]);
            r_pp[7] <= mul_elem(i_m[1], i_m[6]);  r_pq[7] <= mul_elem(i_m[0], i_m[7]);
            r_pp[8] <= mul_elem(i_m[0], i_m[4]);  r_pq[8] <= mul_elem(i_m[1], i_m[3]);
            r_a0 <= i_m[0];
            r_b0 <= i_m[1];
            r_c0 <= i_m[2];
        end
    end

    // stage 1: adjugate entries, row-major
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N_ELEM; j++) begin
                r_adj1[j] <= t_cof'(r_pp[j]) - t_cof'(r_pq[j]);
            end
            r_a1 <= r_a0;
            r_b1 <= r_b0;
            r_c1 <= r_c0;
        end
    end

    // stage 2: first-row expansion products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp[0] <= t_dprod'(r_a1) * t_dprod'(r_adj1[0]);
            r_dp[1] <= t_dprod'(r_b1) * t_dprod'(r_adj1[3]);
            r_dp[2] <= t_dprod'(r_c1) * t_dprod'(r_adj1[6]);
            r_adj2  <= r_adj1;
        end
    end

    // stage 3: determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det  <= t_det'(r_dp[0]) + t_det'(r_dp[1]) + t_det'(r_dp[2]);
            r_adj3 <= r_adj2;
        end
    end

    // stage 4: magnitudes of scaled numerators and divisor, quotient signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N_ELEM; j++) begin
                r_nmag[j] <= r_adj3[j][COF_W-1]
                    ? t_nmag'(-(t_num'(r_adj3[j]) <<< (2 * FRAC_BITS)))
                    : t_nmag'(t_num'(r_adj3[j]) <<< (2 * FRAC_BITS));
                r_side.neg[j] <= r_adj3[j][COF_W-1] ^ r_det[DET_W-1];
            end
            r_side.dmag     <= r_det[DET_W-1] ? t_dmag'(-r_det) : t_dmag'(r_det);
            r_side.singular <= (r_det == '0);
        end
    end

    assign o_nmag = r_nmag;
    assign o_side = r_side;

endmodule

### hw/rtl/m3i_div_lane.sv
// one pipelined restoring divider lane with saturation and output register
module m3i_div_lane import m3i_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_nmag i_nmag,
    input  t_dmag i_dmag,
    input  logic  i_neg,
    input  logic  i_singular,
    output t_elem o_res
);

    t_rem  r_rem [ELEM_WIDTH];
    t_dmag r_d   [ELEM_WIDTH];
    t_quo  r_q   [ELEM_WIDTH+1];
    logic  r_neg [ELEM_WIDTH+1];
    logic  r_ovf [ELEM_WIDTH+1];
    t_elem r_res;

    t_quo lim;
    t_quo qsat;

    // overflow check: quotient at or above 2^ELEM_WIDTH saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= t_rem'(i_nmag);
            r_d[0]   <= i_dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= t_rem'(i_nmag) >= (t_rem'(i_dmag) << ELEM_WIDTH);
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= ELEM_WIDTH; k++) begin : g_step
        localparam int BIT = ELEM_WIDTH - k;
        t_rem sh;
        logic ge;

        assign sh = t_rem'(r_d[k-1]) << BIT;
        assign ge = r_rem[k-1] >= sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= r_q[k-1] | (t_quo'(ge) << BIT);
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < ELEM_WIDTH) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? r_rem[k-1] - sh : r_rem[k-1];
                    r_d[k]   <= r_d[k-1];
                end
            end
        end
    end

    // saturate to the signed range and apply sign
    always_comb begin
        lim  = r_neg[ELEM_WIDTH] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                 : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        qsat = (r_ovf[ELEM_WIDTH] || (r_q[ELEM_WIDTH] > lim)) ? lim : r_q[ELEM_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_singular) begin
                r_res <= '0;
            end else begin
                r_res <= r_neg[ELEM_WIDTH] ? t_elem'(-qsat) : t_elem'(qsat);
            end
        end
    end

    assign o_res = r_res;

endmodule

### dv/tb_matrix3x3_inverse.sv
// self-checking testbench for the pipelined 3x3 fixed-point matrix inverse
`timescale 1ns / 1ps

module tb_matrix3x3_inverse;
    import m3i_pkg::*;

    typedef t_elem t_mat [N_ELEM];

    typedef struct {
        t_elem r [N_ELEM];
        logic  singular;
    } t_inverse;

    // expected inverses in arrival order, plus the exact predictor
    class inverse_scoreboard;
        t_inverse pending_inverses [$];
        int       n_errors;

        function new();
            n_errors = 0;
        endfunction

        static function longint minor2(longint p, longint q, longint r, longint s);
            return p * q - r * s;
        endfunction

        // adjugate over determinant, truncated toward zero and saturated
        function void note_matrix(t_elem m [N_ELEM]);
            longint   a, b, c, d, e, f, g, h, k, det, quo;
            longint   adj [N_ELEM];
            t_inverse exp_inv;
            a = m[0]; b = m[1]; c = m[2];
            d = m[3]; e = m[4]; f = m[5];
            g = m[6]; h = m[7]; k = m[8];
            adj[0] = minor2(e, k, f, h);
            adj[1] = minor2(c, h, b, k);
            adj[2] = minor2(b, f, c, e);
            adj[3] = minor2(f, g, d, k);
            adj[4] = minor2(a, k, c, g);
            adj[5] = minor2(c, d, a, f);
            adj[6] = minor2(d, h, e, g);
            adj[7] = minor2(b, g, a, h);
            adj[8] = minor2(a, e, b, d);
            det = a * adj[0] + b * adj[3] + c * adj[6];
            exp_inv.singular = (det == 0);
            for (int j = 0; j < N_ELEM; j++) begin
                if (det == 0) begin
                    exp_inv.r[j] = '0;
                end else begin
                    quo = (adj[j] * (64'sd1 <<< (2 * FRAC_BITS))) / det;
                    if (quo > 32767) quo = 32767;
                    if (quo < -32768) quo = -32768;
                    exp_inv.r[j] = t_elem'(quo);
                end
            end
            pending_inverses.push_back(exp_inv);
        endfunction

        function void check_inverse(t_inverse got);
            t_inverse   exp_inv;
            string      fname;
            if (pending_inverses.size() == 0) begin
                $error("output word with no matrix pending");
                n_errors++;
                return;
            end
            exp_inv = pending_inverses.pop_front();
            for (int j = 0; j < N_ELEM; j++) begin
                if (got.r[j] !== exp_inv.r[j]) begin
                    fname = $sformatf("r%0d%0d", j / 3, j % 3);
                    $error("%s expected %0d actual %0d", fname, exp_inv.r[j], got.r[j]);
                    n_errors++;
                end
            end
            if (got.singular !== exp_inv.singular) begin
                $error("singular expected %0b actual %0b", exp_inv.singular, got.singular);
                n_errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_RANDOM_PHASE = 250;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    logic  o_stall, o_valid, o_singular;
    t_elem i_m [N_ELEM];
    t_elem o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;

    inverse_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    initial for (int j = 0; j < N_ELEM; j++) i_m[j] = '0;

    always #5 i_clk = ~i_clk;

    matrix3x3_inverse u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(i_m[0]), .i_m01(i_m[1]), .i_m02(i_m[2]),
        .i_m10(i_m[3]), .i_m11(i_m[4]), .i_m12(i_m[5]),
        .i_m20(i_m[6]), .i_m21(i_m[7]), .i_m22(i_m[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_r00(o_r00), .o_r01(o_r01), .o_r02(o_r02),
        .o_r10(o_r10), .o_r11(o_r11), .o_r12(o_r12),
        .o_r20(o_r20), .o_r21(o_r21), .o_r22(o_r22),
        .o_singular(o_singular)
    );

    // receiver backpressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // output word check and watchdog
    always @(posedge i_clk) begin
        t_inverse got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.r[0] = o_r00; got.r[1] = o_r01; got.r[2] = o_r02;
            got.r[3] = o_r10; got.r[4] = o_r11; got.r[5] = o_r12;
            got.r[6] = o_r20; got.r[7] = o_r21; got.r[8] = o_r22;
            got.singular = o_singular;
            sb.check_inverse(got);
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL matrix3x3_inverse");
            $finish;
        end
    end

    // one input word; called just after a falling edge
    task automatic send_matrix(t_mat m);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        for (int j = 0; j < N_ELEM; j++) i_m[j] <= m[j];
        do @(posedge i_clk); while (o_stall);
        sb.note_matrix(m);
        @(negedge i_clk);
    endtask

    task automatic send_diag(int x, int y, int z);
        t_mat m;
        foreach (m[j]) m[j] = '0;
        m[0] = t_elem'(x); m[4] = t_elem'(y); m[8] = t_elem'(z);
        send_matrix(m);
    endtask

    task automatic send_fill(int x);
        t_mat m;
        foreach (m[j]) m[j] = t_elem'(x);
        send_matrix(m);
    endtask

    function automatic t_elem rand_elem(int span);
        if (span == 0) return t_elem'($urandom());
        return t_elem'($urandom_range(0, 2 * span) - span);
    endfunction

    // mostly well-conditioned, some full-range, some forced singular
    task automatic send_random_matrix();
        t_mat m;
        int   kind, span, src, dst;
        kind = $urandom_range(0, 99);
        span = (kind < 15) ? 0 : ((kind < 50) ? 1024 : 256);
        foreach (m[j]) m[j] = rand_elem(span);
        if (kind >= 50 && kind < 70) begin
            m[0] = m[0] + 16'sd512; m[4] = m[4] + 16'sd512; m[8] = m[8] + 16'sd512;
        end else if (kind >= 85 && kind < 92) begin
            src = $urandom_range(0, 2);
            dst = (src + 1 + $urandom_range(0, 1)) % 3;
            for (int c = 0; c < 3; c++) m[dst * 3 + c] = m[src * 3 + c];
        end else if (kind >= 92 && kind < 96) begin
            src = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++) m[r * 3 + src] = '0;
        end else if (kind >= 96) begin
            for (int r = 0; r < 3; r++) m[r * 3 + 2] = m[r * 3] + m[r * 3 + 1];
        end
        send_matrix(m);
    endtask

    initial begin
        t_mat m;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: singular, identity, signs, saturation, extremes
        send_fill(0);
        send_diag(256, 256, 256);
        send_diag(-256, -256, -256);
        send_diag(512, -128, 1024);
        send_diag(1, 1, 1);
        send_diag(-1, 1, -1);
        send_diag(32767, 32767, 32767);
        send_diag(-32768, -32768, -32768);
        send_diag(-32768, 32767, 1);
        send_diag(16, 256, 4096);
        send_fill(32767);
        send_fill(-32768);
        send_fill(256);
        m = '{16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256,
              16'sd256, 16'sd0, 16'sd0};
        send_matrix(m);
        m = '{16'sd512, 16'sd256, 16'sd0, 16'sd256, 16'sd512, 16'sd256,
              16'sd0, 16'sd256, 16'sd512};
        send_matrix(m);
        m = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
              16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767};
        send_matrix(m);
        m = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, 16'sd32767, -16'sd1,
              -16'sd32768, 16'sd0, 16'sd32767};
        send_matrix(m);
        m = '{16'sd256, 16'sd512, 16'sd768, 16'sd1024, 16'sd1280, 16'sd1536,
              16'sd1792, 16'sd2048, 16'sd2304};
        send_matrix(m);
        m = '{16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 16'sd0, 16'sd0, -16'sd5};
        send_matrix(m);

        // random phases with different idle mixes
        send_idle_pct = 25; recv_idle_pct = 48;
        repeat (N_RANDOM_PHASE) send_random_matrix();
        send_idle_pct = 48; recv_idle_pct = 25;
        repeat (N_RANDOM_PHASE) send_random_matrix();
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (N_RANDOM_PHASE) send_random_matrix();
        i_valid <= 1'b0;

        // drain
        while (sb.pending_inverses.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("PASS matrix3x3_inverse");
        end else begin
            $display("FAIL matrix3x3_inverse");
        end
        $finish;
    end

endmodule
